>>> rtl/core/hrc_pkg.sv
// Package for the hysteresis relay controller: item, result and register types and codes.
`default_nettype none

package hrc_pkg;

	localparam int unsigned CfgIndexWidth = 8;
	localparam int unsigned CfgDataWidth  = 12;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_MANUAL = 3'd1,
		MODE_ESTOP  = 3'd2,
		MODE_REARM  = 3'd3,
		MODE_RESUME = 3'd4
	} hrc_mode_t;

	typedef enum logic [1:0] {
		LIGHT_OFF    = 2'd0,
		LIGHT_GREEN  = 2'd1,
		LIGHT_ORANGE = 2'd2,
		LIGHT_RED    = 2'd3
	} hrc_light_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_TEMP_ON_THRESHOLD = 8'd0,
		REG_HYSTERESIS_BAND   = 8'd1,
		REG_HUMIDITY_ALERT    = 8'd2,
		REG_ESTOP_AUTO_REARM  = 8'd3
	} hrc_reg_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [11:0] temperature;
		logic [9:0]         humidity;
		logic               sample_valid;
		logic               contact_closed;
		logic               command_relay;
	} hrc_in_t;

	typedef struct packed {
		logic       relay_on;
		logic [1:0] light_state;
		logic       light_update;
	} hrc_out_t;

	typedef struct packed {
		logic signed [11:0] temp_on_threshold;
		logic [8:0]         hysteresis_band;
		logic [9:0]         humidity_alert;
		logic               estop_auto_rearm;
	} hrc_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/hysteresis_relay_controller.sv
// Top level of the hysteresis relay controller: input stage, decision logic, result register.
// An item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle; the input stage advances whenever the result register is
// empty or its result is transferred in the same cycle.
// Reset (arst_n low, asynchronous): relay off, no stop latched, automatic mode, blink phase 0,
// registers at 280 / 20 / 700 / 0, both stages empty.
`default_nettype none

module hysteresis_relay_controller (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// item channel
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire hrc_pkg::hrc_in_t                   item,
	// result channel
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output hrc_pkg::hrc_out_t                       result,
	// configuration write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [hrc_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  wire logic [hrc_pkg::CfgDataWidth-1:0]   cfg_data
);
	import hrc_pkg::*;

	logic     valid_s1;
	hrc_in_t  item_s1;
	hrc_cfg_t cfg;
	hrc_out_t res;
	logic     res_valid;
	logic     advance;
	logic     fire_s1;

	logic     result_valid_q;
	hrc_out_t result_q;

	// result register can take a new value when empty or being transferred
	assign advance = !result_valid_q || !result_stall;
	// staged item is processed (state updated) exactly once, as it leaves stage 1
	assign fire_s1 = valid_s1 && advance;

	hrc_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	hrc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hrc_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.item      (item_s1),
		.cfg       (cfg),
		.res       (res),
		.res_valid (res_valid)
	);

	// result register: only ticks and estop triggers produce a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= fire_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire_s1 && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// input side only blocks behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item stall without a blocked result");

	// a result without light update is always the estop form
	a_estop_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.light_update)
			|-> (!result.relay_on && result.light_state == LIGHT_OFF))
		else $error("non-updating result is not relay off / light off");

	// estop trigger leaving stage 1 shows up as a result next cycle
	a_estop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.mode == MODE_ESTOP) |=> (result_valid && !result.light_update))
		else $error("estop trigger did not produce its result");

endmodule

`default_nettype wire

>>> rtl/core/hrc_in_stage.sv
// Input register stage of the hysteresis relay controller.
`default_nettype none

module hrc_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire hrc_pkg::hrc_in_t item,
	input  wire logic            advance,
	output logic                 valid_s1,
	output hrc_pkg::hrc_in_t     item_s1
);
	import hrc_pkg::*;

	// hold the staged item while the result side is blocked
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/hrc_cfg_regs.sv
// Configuration register file of the hysteresis relay controller.
`default_nettype none

module hrc_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [hrc_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  wire logic [hrc_pkg::CfgDataWidth-1:0]   cfg_data,
	output hrc_pkg::hrc_cfg_t                       cfg
);
	import hrc_pkg::*;

	hrc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_on_threshold <= 12'sd280;
			cfg_q.hysteresis_band   <= 9'd20;
			cfg_q.humidity_alert    <= 10'd700;
			cfg_q.estop_auto_rearm  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEMP_ON_THRESHOLD: cfg_q.temp_on_threshold <= $signed(cfg_data[11:0]);
				REG_HYSTERESIS_BAND:   cfg_q.hysteresis_band   <= cfg_data[8:0];
				REG_HUMIDITY_ALERT:    cfg_q.humidity_alert    <= cfg_data[9:0];
				REG_ESTOP_AUTO_REARM:  cfg_q.estop_auto_rearm  <= cfg_data[0];
				default: ;  // unmapped index, dropped
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/hrc_decide.sv
// Relay and light decision logic with the controller state registers.
`default_nettype none

module hrc_decide (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire hrc_pkg::hrc_in_t  item,
	input  wire hrc_pkg::hrc_cfg_t cfg,
	output hrc_pkg::hrc_out_t      res,
	output logic                   res_valid
);
	import hrc_pkg::*;

	logic relay_q, blink_q, estop_q, manual_q, level_q;
	logic relay_d, blink_d, estop_d, manual_d, level_d;
	logic signed [12:0] off_level;
	logic signed [12:0] temp_ext;
	logic [1:0]         light;

	assign off_level = {cfg.temp_on_threshold[11], cfg.temp_on_threshold}
		- $signed({4'b0000, cfg.hysteresis_band});
	assign temp_ext  = {item.temperature[11], item.temperature};

	always_comb begin
		relay_d   = relay_q;
		blink_d   = blink_q;
		estop_d   = estop_q;
		manual_d  = manual_q;
		level_d   = level_q;
		light     = LIGHT_OFF;
		res_valid = 1'b0;
		res       = '0;
		case (item.mode)
			MODE_MANUAL: begin
				if (!estop_q) begin
					manual_d = 1'b1;
					level_d  = item.command_relay;
				end
			end
			MODE_ESTOP: begin
				estop_d   = 1'b1;
				relay_d   = 1'b0;
				res_valid = 1'b1;
			end
			MODE_REARM:  estop_d  = 1'b0;
			MODE_RESUME: manual_d = 1'b0;
			MODE_TICK: begin
				if (estop_q && cfg.estop_auto_rearm && !item.contact_closed) begin
					estop_d = 1'b0;
				end
				if (estop_d) begin
					relay_d = 1'b0;
					blink_d = !blink_q;
					light   = blink_d ? LIGHT_RED : LIGHT_OFF;
				end else if (manual_q) begin
					relay_d = level_q;
					light   = LIGHT_ORANGE;
				end else if (!item.sample_valid) begin
					light   = LIGHT_RED;
				end else begin
					if (item.temperature >= cfg.temp_on_threshold) begin
						relay_d = 1'b1;
					end else if (temp_ext <= off_level) begin
						relay_d = 1'b0;
					end
					light = (relay_d || item.humidity > cfg.humidity_alert)
						? LIGHT_ORANGE : LIGHT_GREEN;
				end
				res_valid        = 1'b1;
				res.relay_on     = relay_d;
				res.light_state  = light;
				res.light_update = 1'b1;
			end
			default: ;  // unused codes: no effect
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q  <= 1'b0;
			blink_q  <= 1'b0;
			estop_q  <= 1'b0;
			manual_q <= 1'b0;
			level_q  <= 1'b0;
		end else if (fire) begin
			relay_q  <= relay_d;
			blink_q  <= blink_d;
			estop_q  <= estop_d;
			manual_q <= manual_d;
			level_q  <= level_d;
		end
	end

endmodule

`default_nettype wire
